// ===== rtl/gda_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gda_pkg;

	localparam int unsigned CYCLE_DAYS  = 146097;
	localparam int unsigned CYCLE_YEARS = 400;
	localparam int unsigned LAST_MONTH  = 12;

	localparam logic [4:0] MONTH_LEN [0:15] = '{
		5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_CLAMP,
		ST_CYCLE,
		ST_WALK,
		ST_DONE
	} gda_state_t;

	typedef struct packed {
		logic load;
		logic mod_step;
		logic clamp;
		logic cycle_step;
		logic walk_step;
	} gda_ctl_t;

	typedef struct packed {
		logic mod_ge;
		logic cycle_big;
		logic walk_done;
	} gda_sts_t;

	function automatic logic is_leap(input logic [8:0] r);
		return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
	endfunction

	function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
		return (m == 4'd2 && leap) ? 5'd29 : MONTH_LEN[m];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/gda_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gda_ctrl
	import gda_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire gda_sts_t sts,
	output gda_ctl_t      ctl,
	output logic          busy,
	output logic          done
);

	gda_state_t state_q;
	gda_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = ST_MOD;
				end
			end
			ST_MOD: begin
				ctl.mod_step = 1'b1;
				if (!sts.mod_ge) begin
					state_d = ST_CLAMP;
				end
			end
			ST_CLAMP: begin
				ctl.clamp = 1'b1;
				state_d   = ST_CYCLE;
			end
			ST_CYCLE: begin
				ctl.cycle_step = 1'b1;
				if (!sts.cycle_big) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				ctl.walk_step = 1'b1;
				if (sts.walk_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

`default_nettype wire

// ===== rtl/gda_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gda_dp
	import gda_pkg::*;
#(
	parameter int OFFSET_BITS = 17
) (
	input  wire logic                          clk,
	input  wire gda_ctl_t                      ctl,
	input  wire logic [4:0]                    day,
	input  wire logic [3:0]                    month,
	input  wire logic [13:0]                   year,
	input  wire logic signed [OFFSET_BITS-1:0] offset,
	output gda_sts_t                           sts,
	output logic [4:0]                         result_day,
	output logic [3:0]                         result_month,
	output logic signed [14:0]                 result_year
);

	localparam int OW = ((OFFSET_BITS > 18) ? OFFSET_BITS : 18) + 2;
	localparam logic signed [OW-1:0] CYC = OW'(CYCLE_DAYS);
	localparam logic [13:0] CYC_Y = 14'(CYCLE_YEARS);
	localparam logic [8:0] R_LAST = 9'(CYCLE_YEARS - 1);
	localparam logic [3:0] M_LAST = 4'(LAST_MONTH);

	logic [4:0]           d_q;
	logic [3:0]           m_q;
	logic signed [14:0]   y_q;
	logic [13:0]          r_q;
	logic signed [OW-1:0] off_q;

	logic [4:0]           dim;
	logic [5:0]           rem1;
	logic signed [OW-1:0] addend;
	logic signed [OW-1:0] sum;
	logic                 off_neg;
	logic                 off_zero;
	logic                 sum_neg;
	logic                 sum_zero;
	logic [3:0]           prev_m;
	logic [8:0]           prev_r;
	logic [8:0]           r9;

	assign r9       = r_q[8:0];
	assign dim      = days_in(m_q, is_leap(r9));
	assign rem1     = {1'b0, dim} - {1'b0, d_q} + 6'd1;
	assign off_neg  = off_q[OW-1];
	assign off_zero = (off_q == '0);

	// shared adder: cycle skip, month step and fit test
	always_comb begin
		if (ctl.cycle_step) begin
			addend = off_neg ? CYC : -CYC;
		end else if (off_neg) begin
			addend = $signed(OW'(d_q));
		end else begin
			addend = -$signed(OW'(rem1));
		end
	end

	assign sum      = off_q + addend;
	assign sum_neg  = sum[OW-1];
	assign sum_zero = (sum == '0);

	assign prev_m = (m_q == 4'd1) ? M_LAST : m_q - 4'd1;
	assign prev_r = (m_q != 4'd1) ? r9 : ((r9 == 9'd0) ? R_LAST : r9 - 9'd1);

	assign sts.mod_ge    = (r_q >= CYC_Y);
	assign sts.cycle_big = off_neg ? (sum_neg || sum_zero) : !sum_neg;
	assign sts.walk_done = off_zero;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			d_q   <= (day == 5'd0) ? 5'd1 : day;
			m_q   <= (month == 4'd0) ? 4'd1 : ((month > M_LAST) ? M_LAST : month);
			y_q   <= $signed({1'b0, year});
			r_q   <= year;
			off_q <= OW'(offset);
		end else if (ctl.mod_step) begin
			if (sts.mod_ge) begin
				r_q <= r_q - CYC_Y;
			end
		end else if (ctl.clamp) begin
			if (d_q > dim) begin
				d_q <= dim;
			end
		end else if (ctl.cycle_step) begin
			if (sts.cycle_big) begin
				off_q <= sum;
				y_q   <= off_neg ? y_q - 15'(CYCLE_YEARS) : y_q + 15'(CYCLE_YEARS);
			end
		end else if (ctl.walk_step) begin
			if (!off_zero && !off_neg) begin
				if (sum_neg) begin
					d_q   <= d_q + off_q[4:0];
					off_q <= '0;
				end else begin
					off_q <= sum;
					d_q   <= 5'd1;
					if (m_q == M_LAST) begin
						m_q <= 4'd1;
						y_q <= y_q + 15'sd1;
						r_q <= (r9 == R_LAST) ? 14'd0 : r_q + 14'd1;
					end else begin
						m_q <= m_q + 4'd1;
					end
				end
			end else if (off_neg) begin
				if (!sum_neg && !sum_zero) begin
					d_q   <= sum[4:0];
					off_q <= '0;
				end else begin
					off_q <= sum;
					m_q   <= prev_m;
					r_q   <= {5'd0, prev_r};
					d_q   <= days_in(prev_m, is_leap(prev_r));
					if (m_q == 4'd1) begin
						y_q <= y_q - 15'sd1;
					end
				end
			end
		end
	end

	assign result_day   = d_q;
	assign result_month = m_q;
	assign result_year  = y_q;

endmodule

`default_nettype wire

// ===== rtl/gregorian_date_add_days_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Adds a signed day offset to a Gregorian date. A word is taken when start is high and busy
// is low; busy then stays high until done pulses for one cycle with the result on result_day,
// result_month and result_year, which must be captured in that cycle since there is no stall.
// The year is reduced modulo 400, the day is clamped to its month, whole 146097-day cycles in
// the offset are skipped, and the date then walks a month at a time, with a last step when a
// nonzero offset ends inside a month; cycles and months go through one shared adder, and one
// word is in flight at a time.

module gregorian_date_add_days_core
	import gda_pkg::*;
#(
	parameter int OFFSET_BITS = 17
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [4:0]                    day,
	input  wire logic [3:0]                    month,
	input  wire logic [13:0]                   year,
	input  wire logic signed [OFFSET_BITS-1:0] offset,
	output logic                               done,
	output logic [4:0]                         result_day,
	output logic [3:0]                         result_month,
	output logic signed [14:0]                 result_year
);

	gda_ctl_t ctl;
	gda_sts_t sts;

	gda_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	gda_dp #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_dp (
		.clk          (clk),
		.ctl          (ctl),
		.day          (day),
		.month        (month),
		.year         (year),
		.offset       (offset),
		.sts          (sts),
		.result_day   (result_day),
		.result_month (result_month),
		.result_year  (result_year)
	);

endmodule

`default_nettype wire

// ===== rtl/gda_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gda_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire logic [4:0] result_day,
	input wire logic [3:0] result_month
);

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("word taken but not busy");

	a_month_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result_month >= 4'd1 && result_month <= 4'd12 && result_day != 5'd0))
		else $error("result date out of range");

endmodule

bind gregorian_date_add_days_core gda_checker u_gda_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.result_day   (result_day),
	.result_month (result_month)
);

`default_nettype wire
